// ----- src/tmnd_pkg.sv -----
// shared types, constants and register codes of the trigger to note detector
package tmnd_pkg;

    // channel counts and fixed field widths
    localparam int NUM_CHANNELS = 3;
    localparam int MAX_CHANNELS = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int CH_W         = 2;
    localparam int SAMPLE_W     = 12;
    localparam int COUNT_W      = 9;
    localparam int TICKS_W      = 24;
    localparam int ATTACK_W     = 8;
    localparam int PITCH_W      = 7;
    localparam int VEL_W        = 7;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    // input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // per channel note phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_HOLD    = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_THRESHOLD    = 3'd0,
        CFG_OFF_THRESHOLD   = 3'd1,
        CFG_ATTACK_SAMPLES  = 3'd2,
        CFG_RELEASE_SAMPLES = 3'd3,
        CFG_TIMEOUT_TICKS   = 3'd4,
        CFG_PITCH_CH0       = 3'd5,
        CFG_PITCH_CH1       = 3'd6,
        CFG_PITCH_CH2       = 3'd7
    } cfg_idx_t;

    // configuration register file contents
    typedef struct packed {
        logic [SAMPLE_W-1:0]                    on_threshold;
        logic [SAMPLE_W-1:0]                    off_threshold;
        logic [ATTACK_W-1:0]                    attack_samples;
        logic [ATTACK_W-1:0]                    release_samples;
        logic [TICKS_W-1:0]                     timeout_ticks;
        logic [MAX_CHANNELS-1:0][PITCH_W-1:0]   pitch;
    } cfg_t;

    // reset values of the registers
    localparam logic [SAMPLE_W-1:0] RST_ON_THRESHOLD    = 12'd530;
    localparam logic [SAMPLE_W-1:0] RST_OFF_THRESHOLD   = 12'd25;
    localparam logic [ATTACK_W-1:0] RST_ATTACK_SAMPLES  = 8'd10;
    localparam logic [ATTACK_W-1:0] RST_RELEASE_SAMPLES = 8'd10;
    localparam logic [TICKS_W-1:0]  RST_TIMEOUT_TICKS   = 24'd500000;
    localparam logic [PITCH_W-1:0]  RST_PITCH_CH0       = 7'd64;
    localparam logic [PITCH_W-1:0]  RST_PITCH_CH1       = 7'd60;
    localparam logic [PITCH_W-1:0]  RST_PITCH_CH2       = 7'd56;

endpackage

// ----- src/tmnd_front.sv -----
// front part: per channel phase tracking and polling pass, emits event packets
module tmnd_front #(
    parameter int CHANNELS = tmnd_pkg::NUM_CHANNELS,
    parameter int PKT_W    = CHANNELS * (2 + tmnd_pkg::SAMPLE_W)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tmnd_pkg::cfg_t                cfg,
    input  logic                          accept,
    input  logic                          opcode,
    input  logic [tmnd_pkg::CH_W-1:0]     channel,
    input  logic [tmnd_pkg::SAMPLE_W-1:0] sample,
    output logic                          q_push,
    output logic [PKT_W-1:0]              q_data
);
    import tmnd_pkg::*;

    phase_t                            phase_reg [CHANNELS];
    logic [SAMPLE_W-1:0]               peak_reg  [CHANNELS];
    logic [COUNT_W-1:0]                count_reg [CHANNELS];
    logic [TICKS_W-1:0]                ticks_reg [CHANNELS];

    logic [CHANNELS-1:0]               ev_mask;
    logic [CHANNELS-1:0]               ev_on;
    logic [CHANNELS-1:0][SAMPLE_W-1:0] ev_peak;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        phase_t              phase_next;
        logic [SAMPLE_W-1:0] peak_next;
        logic [COUNT_W-1:0]  count_next;
        logic [TICKS_W-1:0]  ticks_next;
        logic                hit;
        logic                tick;
        logic                ev;
        logic                on;

        assign hit  = accept && (opcode == OP_SAMPLE) && (channel == CH_W'(c));
        assign tick = accept && (opcode == OP_TICK);

        // input update followed by this lane's slot of the polling pass
        always_comb
        begin
            phase_next = phase_reg[c];
            peak_next  = peak_reg[c];
            count_next = count_reg[c];
            ticks_next = ticks_reg[c];
            ev         = 1'b0;
            on         = 1'b0;

            // sample for this channel
            if (hit)
            begin
                case (phase_reg[c])
                    PH_IDLE:
                    begin
                        if (sample > cfg.on_threshold)
                        begin
                            peak_next  = sample;
                            phase_next = PH_ATTACK;
                        end
                    end
                    PH_ATTACK:
                    begin
                        if (count_reg[c] < {1'b0, cfg.attack_samples})
                        begin
                            count_next = count_reg[c] + COUNT_W'(1);
                            if (sample > peak_reg[c])
                            begin
                                peak_next = sample;
                            end
                        end
                    end
                    PH_HOLD:
                    begin
                        if (sample < cfg.off_threshold)
                        begin
                            if (count_reg[c] != '1)
                            begin
                                count_next = count_reg[c] + COUNT_W'(1);
                            end
                        end
                        else
                        begin
                            count_next = '0;
                        end
                        if (count_next > {1'b0, cfg.release_samples})
                        begin
                            phase_next = PH_RELEASE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // saturating tick count while the note sounds
            if (tick && (phase_reg[c] == PH_HOLD || phase_reg[c] == PH_RELEASE)
                && ticks_reg[c] != '1)
            begin
                ticks_next = ticks_reg[c] + TICKS_W'(1);
            end

            // polling pass: at most one event per channel
            case (phase_next)
                PH_ATTACK:
                begin
                    if (count_next >= {1'b0, cfg.attack_samples})
                    begin
                        ev         = 1'b1;
                        on         = 1'b1;
                        phase_next = PH_HOLD;
                        count_next = '0;
                        ticks_next = '0;
                    end
                end
                PH_HOLD, PH_RELEASE:
                begin
                    if (phase_next == PH_RELEASE || ticks_next >= cfg.timeout_ticks)
                    begin
                        ev         = 1'b1;
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // lane state, updated once per accepted transaction
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                phase_reg[c] <= PH_IDLE;
                peak_reg[c]  <= '0;
                count_reg[c] <= '0;
                ticks_reg[c] <= '0;
            end
            else if (accept)
            begin
                phase_reg[c] <= phase_next;
                peak_reg[c]  <= peak_next;
                count_reg[c] <= count_next;
                ticks_reg[c] <= ticks_next;
            end
        end

        assign ev_mask[c] = accept && ev;
        assign ev_on[c]   = on;
        assign ev_peak[c] = peak_next;
    end

    // only steps that produce events go into the queue
    assign q_push = |ev_mask;
    assign q_data = {ev_peak, ev_on, ev_mask};

endmodule

// ----- src/tmnd_queue.sv -----
// short packet queue between the front and back parts
module tmnd_queue #(
    parameter int WIDTH = 42,
    parameter int DEPTH = tmnd_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // pointer wrap
    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // the front never writes a full queue, the back never reads an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");

endmodule

// ----- src/tmnd_back.sv -----
// back part: splits event packets into single note transactions
module tmnd_back #(
    parameter int CHANNELS = tmnd_pkg::NUM_CHANNELS,
    parameter int PKT_W    = CHANNELS * (2 + tmnd_pkg::SAMPLE_W)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tmnd_pkg::cfg_t               cfg,
    input  logic [PKT_W-1:0]             q_data,
    input  logic                         q_empty,
    output logic                         q_pop,
    output logic                         empty,
    input  logic                         pop,
    output logic                         note_on,
    output logic [tmnd_pkg::CH_W-1:0]    out_channel,
    output logic [tmnd_pkg::PITCH_W-1:0] pitch,
    output logic [tmnd_pkg::VEL_W-1:0]   velocity,
    output logic                         last
);
    import tmnd_pkg::*;

    localparam int PROD_W = SAMPLE_W + 8;

    logic                              valid_reg;
    logic [CHANNELS-1:0]               mask_reg;
    logic [CHANNELS-1:0]               on_reg;
    logic [CHANNELS-1:0][SAMPLE_W-1:0] peak_reg;

    logic [CHANNELS-1:0]               sel_oh;
    logic [CH_W-1:0]                   sel;
    logic [CHANNELS-1:0]               rest;
    logic                              sel_on;
    logic [SAMPLE_W-1:0]               sel_peak;
    logic [PROD_W-1:0]                 prod;
    logic [PROD_W-1:0]                 scaled;
    logic                              fire;
    logic                              load;

    // lowest pending channel of the current packet
    always_comb
    begin
        sel_oh   = '0;
        sel      = '0;
        sel_on   = 1'b0;
        sel_peak = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel_oh    = '0;
                sel_oh[i] = 1'b1;
                sel       = CH_W'(i);
            end
        end
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (sel_oh[i])
            begin
                sel_on   = on_reg[i];
                sel_peak = peak_reg[i];
            end
        end
    end

    assign rest = mask_reg & ~sel_oh;

    // velocity = peak * 127 / 4095, with x / 4095 = (x + (x >> 12) + 1) >> 12
    assign prod   = {1'b0, sel_peak, 7'd0} - {8'd0, sel_peak};
    assign scaled = prod + (prod >> SAMPLE_W) + PROD_W'(1);

    assign empty       = !valid_reg;
    assign note_on     = sel_on;
    assign out_channel = sel;
    assign pitch       = cfg.pitch[sel];
    assign velocity    = sel_on ? scaled[SAMPLE_W +: VEL_W] : '0;
    assign last        = (rest == '0);

    // packet handoff
    assign fire  = valid_reg && pop;
    assign load  = !valid_reg || (fire && last);
    assign q_pop = load && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            mask_reg <= q_data[CHANNELS-1:0];
            on_reg   <= q_data[2*CHANNELS-1:CHANNELS];
            peak_reg <= q_data[PKT_W-1:2*CHANNELS];
        end
        else if (fire)
        begin
            mask_reg <= rest;
        end
    end

    // a held packet always has an event left, and a non-final one keeps it held
    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (mask_reg != '0))
        else $error("held packet without pending event");
    a_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !last) |=> valid_reg)
        else $error("packet dropped before its last event");

endmodule

// ----- src/trigger_to_midi_note_detector.sv -----
// top level: configuration registers, front part, queue and back part
//
//  channel   direction  handshake          payload
//  input     in         push / full        opcode, channel, sample
//  result    out        empty / pop        note_on, out_channel, pitch, velocity, last
//  config    in         cfg_we             cfg_index, cfg_data
//
// one input transaction is taken per cycle while full is low; its state update
// and polling pass finish in that cycle and the events go to a QUEUE_DEPTH packet
// queue. the back part sends one result per cycle while pop is high, one for each
// event of a step; full rises only when the packet queue is full.
// reset is asynchronous and active low; it clears all channel state and loads the
// register reset values. a stalled result holds on the ports until popped.
module trigger_to_midi_note_detector #(
    parameter int CHANNELS    = tmnd_pkg::NUM_CHANNELS,
    parameter int QUEUE_DEPTH = tmnd_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            opcode,
    input  logic [tmnd_pkg::CH_W-1:0]       channel,
    input  logic [tmnd_pkg::SAMPLE_W-1:0]   sample,
    output logic                            empty,
    input  logic                            pop,
    output logic                            note_on,
    output logic [tmnd_pkg::CH_W-1:0]       out_channel,
    output logic [tmnd_pkg::PITCH_W-1:0]    pitch,
    output logic [tmnd_pkg::VEL_W-1:0]      velocity,
    output logic                            last,
    input  logic                            cfg_we,
    input  logic [tmnd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmnd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tmnd_pkg::*;

    localparam int PKT_W = CHANNELS * (2 + SAMPLE_W);

    cfg_t             cfg_reg;
    logic             accept;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic [PKT_W-1:0] q_wdata;
    logic [PKT_W-1:0] q_rdata;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_threshold    <= RST_ON_THRESHOLD;
            cfg_reg.off_threshold   <= RST_OFF_THRESHOLD;
            cfg_reg.attack_samples  <= RST_ATTACK_SAMPLES;
            cfg_reg.release_samples <= RST_RELEASE_SAMPLES;
            cfg_reg.timeout_ticks   <= RST_TIMEOUT_TICKS;
            cfg_reg.pitch[0]        <= RST_PITCH_CH0;
            cfg_reg.pitch[1]        <= RST_PITCH_CH1;
            cfg_reg.pitch[2]        <= RST_PITCH_CH2;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ON_THRESHOLD:    cfg_reg.on_threshold    <= cfg_data[SAMPLE_W-1:0];
                CFG_OFF_THRESHOLD:   cfg_reg.off_threshold   <= cfg_data[SAMPLE_W-1:0];
                CFG_ATTACK_SAMPLES:  cfg_reg.attack_samples  <= cfg_data[ATTACK_W-1:0];
                CFG_RELEASE_SAMPLES: cfg_reg.release_samples <= cfg_data[ATTACK_W-1:0];
                CFG_TIMEOUT_TICKS:   cfg_reg.timeout_ticks   <= cfg_data[TICKS_W-1:0];
                CFG_PITCH_CH0:       cfg_reg.pitch[0]        <= cfg_data[PITCH_W-1:0];
                CFG_PITCH_CH1:       cfg_reg.pitch[1]        <= cfg_data[PITCH_W-1:0];
                CFG_PITCH_CH2:       cfg_reg.pitch[2]        <= cfg_data[PITCH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input transaction
    assign full   = q_full;
    assign accept = push && !q_full;

    tmnd_front #(
        .CHANNELS (CHANNELS),
        .PKT_W    (PKT_W)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .accept  (accept),
        .opcode  (opcode),
        .channel (channel),
        .sample  (sample),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    tmnd_queue #(
        .WIDTH (PKT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    tmnd_back #(
        .CHANNELS (CHANNELS),
        .PKT_W    (PKT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_data      (q_rdata),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .note_on     (note_on),
        .out_channel (out_channel),
        .pitch       (pitch),
        .velocity    (velocity),
        .last        (last)
    );

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench of the trigger to note detector: directed table, then random strikes
`timescale 1ns / 1ps

module tb_top;
    import tmnd_pkg::*;

    localparam int FULL_SCALE   = 4095;
    localparam int VEL_TOP      = 127;
    localparam int SETTLE_CYC   = 4;
    localparam int ITEMS_PER_CFG = 40;

    // one note event as it leaves the block
    typedef struct packed {
        logic               note_on;
        logic [CH_W-1:0]    chan;
        logic [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]   vel;
        logic               last;
    } note_event_t;

    // rows of the directed table
    typedef enum {ROW_WRITE, ROW_ITEM} row_kind_t;
    typedef enum {EXP_MODEL, EXP_NONE, EXP_EVENT} row_check_t;

    typedef struct {
        row_kind_t            kind;
        cfg_idx_t             idx;
        logic [CFG_DATA_W-1:0] data;
        logic                 op;
        logic [CH_W-1:0]      ch;
        logic [SAMPLE_W-1:0]  smp;
        row_check_t           check;
        logic                 on;
        logic [CH_W-1:0]      ech;
        logic [VEL_W-1:0]     vel;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic                  opcode;
    logic [CH_W-1:0]       channel;
    logic [SAMPLE_W-1:0]   sample;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  note_on;
    logic [CH_W-1:0]       out_channel;
    logic [PITCH_W-1:0]    pitch;
    logic [VEL_W-1:0]      velocity;
    logic                  last;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // register copy of the note detector
    logic [SAMPLE_W-1:0] on_thr;
    logic [SAMPLE_W-1:0] off_thr;
    logic [ATTACK_W-1:0] attack_n;
    logic [ATTACK_W-1:0] release_n;
    logic [TICKS_W-1:0]  timeout_n;
    logic [PITCH_W-1:0]  pitch_tab [NUM_CHANNELS];

    // per channel note state
    phase_t              ch_phase [NUM_CHANNELS];
    logic [SAMPLE_W-1:0] ch_peak  [NUM_CHANNELS];
    logic [COUNT_W-1:0]  ch_count [NUM_CHANNELS];
    logic [TICKS_W-1:0]  ch_ticks [NUM_CHANNELS];

    note_event_t step_events [$];
    note_event_t pending_events [$];
    stim_row_t   stim_table [$];

    int tx_idle_pct = 13;
    int rx_idle_pct = 52;
    int error_count = 0;
    int items_sent = 0;
    int events_checked = 0;
    int reg_writes = 0;

    trigger_to_midi_note_detector DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .channel     (channel),
        .sample      (sample),
        .empty       (empty),
        .pop         (pop),
        .note_on     (note_on),
        .out_channel (out_channel),
        .pitch       (pitch),
        .velocity    (velocity),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // reset state of the predictor
    function automatic void reset_detector();
        on_thr    = RST_ON_THRESHOLD;
        off_thr   = RST_OFF_THRESHOLD;
        attack_n  = RST_ATTACK_SAMPLES;
        release_n = RST_RELEASE_SAMPLES;
        timeout_n = RST_TIMEOUT_TICKS;
        pitch_tab[0] = RST_PITCH_CH0;
        pitch_tab[1] = RST_PITCH_CH1;
        pitch_tab[2] = RST_PITCH_CH2;
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            ch_phase[k] = PH_IDLE;
            ch_peak[k]  = '0;
            ch_count[k] = '0;
            ch_ticks[k] = '0;
        end
    endfunction

    function automatic void apply_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ON_THRESHOLD:    on_thr = data[SAMPLE_W-1:0];
            CFG_OFF_THRESHOLD:   off_thr = data[SAMPLE_W-1:0];
            CFG_ATTACK_SAMPLES:  attack_n = data[ATTACK_W-1:0];
            CFG_RELEASE_SAMPLES: release_n = data[ATTACK_W-1:0];
            CFG_TIMEOUT_TICKS:   timeout_n = data[TICKS_W-1:0];
            CFG_PITCH_CH0:       pitch_tab[0] = data[PITCH_W-1:0];
            CFG_PITCH_CH1:       pitch_tab[1] = data[PITCH_W-1:0];
            CFG_PITCH_CH2:       pitch_tab[2] = data[PITCH_W-1:0];
            default: ;
        endcase
    endfunction

    // one step: apply the input, then poll channels in order and collect events
    function automatic void step_detector(logic op, logic [CH_W-1:0] ch,
                                          logic [SAMPLE_W-1:0] smp);
        int k;
        note_event_t ev;
        step_events.delete();
        if (op == OP_SAMPLE)
        begin
            if (ch < NUM_CHANNELS)
            begin
                k = ch;
                case (ch_phase[k])
                    PH_IDLE:
                        if (smp > on_thr)
                        begin
                            ch_peak[k]  = smp;
                            ch_phase[k] = PH_ATTACK;
                        end
                    PH_ATTACK:
                        if (ch_count[k] < attack_n)
                        begin
                            ch_count[k]++;
                            if (smp > ch_peak[k])
                                ch_peak[k] = smp;
                        end
                    PH_HOLD:
                    begin
                        // quiet samples count up, anything louder starts over
                        if (smp < off_thr)
                        begin
                            if (ch_count[k] != '1)
                                ch_count[k]++;
                        end
                        else
                            ch_count[k] = '0;
                        if (ch_count[k] > release_n)
                            ch_phase[k] = PH_RELEASE;
                    end
                    default: ;
                endcase
            end
        end
        else
        begin
            // tick ages every held note, saturating
            for (k = 0; k < NUM_CHANNELS; k++)
                if ((ch_phase[k] == PH_HOLD || ch_phase[k] == PH_RELEASE) && ch_ticks[k] != '1)
                    ch_ticks[k]++;
        end

        // polling pass, at most one event per channel
        for (k = 0; k < NUM_CHANNELS; k++)
        begin
            ev.chan  = k[CH_W-1:0];
            ev.pitch = pitch_tab[k];
            ev.last  = 1'b0;
            if (ch_phase[k] == PH_ATTACK)
            begin
                if (ch_count[k] >= attack_n)
                begin
                    ev.note_on = 1'b1;
                    ev.vel = VEL_W'((int'(ch_peak[k]) * VEL_TOP) / FULL_SCALE);
                    step_events.push_back(ev);
                    ch_phase[k] = PH_HOLD;
                    ch_count[k] = '0;
                    ch_ticks[k] = '0;
                end
            end
            else if (ch_phase[k] == PH_HOLD || ch_phase[k] == PH_RELEASE)
            begin
                if (ch_phase[k] == PH_RELEASE || ch_ticks[k] >= timeout_n)
                begin
                    ev.note_on = 1'b0;
                    ev.vel = '0;
                    step_events.push_back(ev);
                    ch_phase[k] = PH_IDLE;
                    ch_count[k] = '0;
                end
            end
        end
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].last = 1'b1;
    endfunction

    // directed table rows
    function automatic void add_write(cfg_idx_t idx, int data);
        stim_row_t r;
        r = '{default: '0, kind: ROW_WRITE, idx: idx, check: EXP_NONE};
        r.data = CFG_DATA_W'(data);
        stim_table.push_back(r);
    endfunction

    function automatic void add_item(logic op, int ch, int smp, row_check_t check,
                                     logic on, int ech, int vel);
        stim_row_t r;
        r = '{default: '0, kind: ROW_ITEM, idx: CFG_ON_THRESHOLD, check: check};
        r.op  = op;
        r.ch  = CH_W'(ch);
        r.smp = SAMPLE_W'(smp);
        r.on  = on;
        r.ech = CH_W'(ech);
        r.vel = VEL_W'(vel);
        stim_table.push_back(r);
    endfunction

    // random item that mostly follows each channel's note life
    function automatic void pick_item(output logic op, output logic [CH_W-1:0] ch,
                                      output logic [SAMPLE_W-1:0] smp);
        int r;
        int k;
        r   = $urandom_range(99);
        op  = OP_SAMPLE;
        ch  = CH_W'($urandom);
        smp = SAMPLE_W'($urandom);
        if (r < 14)
            op = OP_TICK;
        else if (r < 18)
            ch = CH_W'(NUM_CHANNELS);
        else
        begin
            k  = $urandom_range(NUM_CHANNELS - 1);
            ch = CH_W'(k);
            if (ch_phase[k] == PH_IDLE && on_thr != '1 && $urandom_range(99) < 70)
                smp = SAMPLE_W'($urandom_range(FULL_SCALE, int'(on_thr) + 1));
            else if ((ch_phase[k] == PH_HOLD || ch_phase[k] == PH_RELEASE)
                     && off_thr != '0 && $urandom_range(99) < 75)
                smp = SAMPLE_W'($urandom_range(int'(off_thr) - 1, 0));
        end
    endfunction

    // send one transaction and wait until it is taken
    task automatic send_item(logic op, logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        opcode  <= op;
        channel <= ch;
        sample  <= smp;
        @(posedge clk);
        while (full !== 1'b0)
            @(posedge clk);
        items_sent++;
    endtask

    // stop sending and let every expected event come out
    task automatic drain_events();
        push <= 1'b0;
        while (pending_events.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic randomize_regs();
        drain_events();
        write_reg(CFG_OFF_THRESHOLD, CFG_DATA_W'($urandom_range(1500, 1)));
        write_reg(CFG_ON_THRESHOLD, CFG_DATA_W'($urandom_range(3000, 0)));
        write_reg(CFG_ATTACK_SAMPLES, CFG_DATA_W'($urandom_range(6, 1)));
        write_reg(CFG_RELEASE_SAMPLES, CFG_DATA_W'($urandom_range(6, 0)));
        if ($urandom_range(5) == 0)
            write_reg(CFG_TIMEOUT_TICKS, '1);
        else
            write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'($urandom_range(40, 1)));
        write_reg(CFG_PITCH_CH0, CFG_DATA_W'($urandom_range(127)));
        write_reg(CFG_PITCH_CH1, CFG_DATA_W'($urandom_range(127)));
        write_reg(CFG_PITCH_CH2, CFG_DATA_W'($urandom_range(127)));
    endtask

    // result side: random pop and check of every popped event
    always @(posedge clk)
    begin
        note_event_t want;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && empty === 1'b0)
            begin
                if (pending_events.size() == 0)
                    report_mismatch($sformatf("unexpected event, channel %0d note_on %0d",
                                              out_channel, note_on));
                else
                begin
                    want = pending_events.pop_front();
                    events_checked++;
                    if (note_on !== want.note_on)
                        report_mismatch($sformatf("note_on got %0d expected %0d",
                                                  note_on, want.note_on));
                    if (out_channel !== want.chan)
                        report_mismatch($sformatf("out_channel got %0d expected %0d",
                                                  out_channel, want.chan));
                    if (pitch !== want.pitch)
                        report_mismatch($sformatf("pitch got %0d expected %0d",
                                                  pitch, want.pitch));
                    if (velocity !== want.vel)
                        report_mismatch($sformatf("velocity got %0d expected %0d",
                                                  velocity, want.vel));
                    if (last !== want.last)
                        report_mismatch($sformatf("last got %0d expected %0d",
                                                  last, want.last));
                end
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // stimulus
    initial
    begin
        logic op;
        logic [CH_W-1:0] ch;
        logic [SAMPLE_W-1:0] smp;
        note_event_t ev;
        int counted;

        rst_n     = 1'b0;
        push      = 1'b0;
        opcode    = OP_SAMPLE;
        channel   = '0;
        sample    = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ON_THRESHOLD;
        cfg_data  = '0;
        reset_detector();

        // single sample attack, release at once
        add_write(CFG_ATTACK_SAMPLES, 1);
        add_write(CFG_RELEASE_SAMPLES, 0);
        add_item(OP_SAMPLE, 0, 4095, EXP_NONE, 0, 0, 0);
        add_item(OP_SAMPLE, 0, 0, EXP_EVENT, 1, 0, 127);
        add_item(OP_SAMPLE, 0, 0, EXP_EVENT, 0, 0, 0);
        // sample equal to the threshold, channel out of range, tick on idle channels
        add_item(OP_SAMPLE, 1, 530, EXP_NONE, 0, 0, 0);
        add_item(OP_SAMPLE, 3, 4095, EXP_NONE, 0, 0, 0);
        add_item(OP_TICK, 3, 4095, EXP_NONE, 0, 0, 0);
        // lowest thresholds, peak raised during attack, timeout after one tick
        add_write(CFG_ON_THRESHOLD, 0);
        add_write(CFG_OFF_THRESHOLD, 0);
        add_item(OP_SAMPLE, 1, 1, EXP_NONE, 0, 0, 0);
        add_item(OP_SAMPLE, 1, 4095, EXP_EVENT, 1, 1, 127);
        add_write(CFG_TIMEOUT_TICKS, 1);
        add_item(OP_TICK, 0, 0, EXP_EVENT, 0, 1, 0);
        // zero attack gives note-on in the trigger step
        add_write(CFG_ATTACK_SAMPLES, 0);
        add_item(OP_SAMPLE, 2, 32, EXP_EVENT, 1, 2, 0);
        // zero timeout releases a held note on the next pass
        add_write(CFG_TIMEOUT_TICKS, 0);
        add_item(OP_SAMPLE, 0, 4095, EXP_MODEL, 0, 0, 0);
        add_item(OP_TICK, 0, 0, EXP_MODEL, 0, 0, 0);
        // highest threshold lets nothing through
        add_write(CFG_ON_THRESHOLD, 4095);
        add_item(OP_SAMPLE, 0, 4095, EXP_NONE, 0, 0, 0);
        // top settings
        add_write(CFG_ON_THRESHOLD, 4094);
        add_write(CFG_OFF_THRESHOLD, 4095);
        add_write(CFG_ATTACK_SAMPLES, 255);
        add_write(CFG_RELEASE_SAMPLES, 255);
        add_write(CFG_TIMEOUT_TICKS, 24'hFFFFFF);
        add_write(CFG_PITCH_CH0, 127);
        add_write(CFG_PITCH_CH1, 0);
        add_write(CFG_PITCH_CH2, 127);
        add_item(OP_SAMPLE, 0, 4095, EXP_NONE, 0, 0, 0);
        add_item(OP_SAMPLE, 1, 4095, EXP_NONE, 0, 0, 0);
        add_item(OP_SAMPLE, 2, 4095, EXP_NONE, 0, 0, 0);
        add_item(OP_SAMPLE, 0, 2048, EXP_NONE, 0, 0, 0);
        add_item(OP_SAMPLE, 1, 1, EXP_NONE, 0, 0, 0);
        add_item(OP_SAMPLE, 2, 0, EXP_NONE, 0, 0, 0);
        // attack register lowered mid attack: all three channels fire on one pass
        add_write(CFG_ATTACK_SAMPLES, 1);
        add_item(OP_TICK, 0, 0, EXP_MODEL, 0, 0, 0);
        add_item(OP_SAMPLE, 1, 4094, EXP_NONE, 0, 0, 0);
        // three timeouts on one tick
        add_write(CFG_TIMEOUT_TICKS, 1);
        add_item(OP_TICK, 0, 0, EXP_MODEL, 0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_WRITE)
            begin
                drain_events();
                write_reg(stim_table[i].idx, stim_table[i].data);
            end
            else
            begin
                send_item(stim_table[i].op, stim_table[i].ch, stim_table[i].smp);
                step_detector(stim_table[i].op, stim_table[i].ch, stim_table[i].smp);
                if (stim_table[i].check == EXP_MODEL)
                    foreach (step_events[j])
                        pending_events.push_back(step_events[j]);
                else if (stim_table[i].check == EXP_EVENT)
                begin
                    ev.note_on = stim_table[i].on;
                    ev.chan    = stim_table[i].ech;
                    ev.pitch   = pitch_tab[stim_table[i].ech];
                    ev.vel     = stim_table[i].vel;
                    ev.last    = 1'b1;
                    pending_events.push_back(ev);
                end
            end
        end

        // random part in three idling phases, two register settings each
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: begin tx_idle_pct = 13; rx_idle_pct = 52; end
                1: begin tx_idle_pct = 52; rx_idle_pct = 13; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int part = 0; part < 2; part++)
            begin
                randomize_regs();
                counted = 0;
                while (counted < ITEMS_PER_CFG)
                begin
                    pick_item(op, ch, smp);
                    send_item(op, ch, smp);
                    step_detector(op, ch, smp);
                    foreach (step_events[j])
                        pending_events.push_back(step_events[j]);
                    if (!(op == OP_SAMPLE && ch >= NUM_CHANNELS))
                        counted++;
                end
            end
        end

        drain_events();
        repeat (20) @(posedge clk);
        $display("sent %0d input transactions under %0d register writes",
                 items_sent, reg_writes);
        $display("checked %0d note events across three idling phases", events_checked);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
